// ===== src/assert_macros.svh =====
// Assertion macros shared by the step period ramp RTL.
// Clock aclk and active-low reset aresetn are taken from the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SSRP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SSRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/ssrp_pkg.sv =====
// Types, constants and helpers for the stepper speed ramp / step period block.
// No dependencies; used by ssrp_ctrl, ssrp_datapath and the top level.
package ssrp_pkg;

    localparam int SPEED_W    = 11;
    localparam int PERIOD_W   = 16;
    localparam int ACCEL_W    = 8;
    localparam int MAG_W      = 10;
    localparam int SLOT_COUNT = 8;
    localparam int SUB_W      = 3;
    // 16 quotient bits of the base period, then 3 more for the remainder share
    localparam int DIV_STEPS  = PERIOD_W + SUB_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic signed [SPEED_W-1:0] SPEED_MIN_PATTERN = 11'sh400;
    localparam logic signed [SPEED_W-1:0] SPEED_NEG_LIMIT   = -11'sd1023;
    localparam logic [PERIOD_W-1:0]       ZERO_SPEED_PERIOD = 16'hFFFF;

    localparam logic [ACCEL_W-1:0]  ACCEL_LIMIT_RESET = 8'd7;
    localparam logic [PERIOD_W-1:0] DIVIDEND_RESET    = 16'd1000;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL_LIMIT     = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD_DIVIDEND = 1'b1;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 144;
    localparam int SLOT_LSB  = SPEED_W + 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RAMP,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic ramp;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } status_t;

    // Position of each slot in the +1 spreading order 1,5,3,7,0,4,2.
    // Slot 6 never receives the extra count.
    function automatic logic [SUB_W-1:0] slot_rank(input logic [SUB_W-1:0] slot);
        logic [SUB_W-1:0] r;
        case (slot)
            3'd1:    r = 3'd0;
            3'd5:    r = 3'd1;
            3'd3:    r = 3'd2;
            3'd7:    r = 3'd3;
            3'd0:    r = 3'd4;
            3'd4:    r = 3'd5;
            3'd2:    r = 3'd6;
            default: r = 3'd7;
        endcase
        return r;
    endfunction

endpackage

// ===== src/stepper_speed_ramp_period.sv =====
// An input transaction passes through the ramp step, the bit-serial divider and
// the output register. Only one transaction is in flight: the sequencer steps
// through idle, ramp, divide and done, and done waits for the output register to
// free up; the next input is taken while the previous result still waits.
// Reset (aresetn low, synchronous): speeds and directions cleared, acceleration
// limit 7, period_dividend 1000, no result pending.
`include "assert_macros.svh"

module stepper_speed_ramp_period #(
    parameter int NUM_MOTORS = 2
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [10:0] target_speed, [15:11] zero
    input  logic [ssrp_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // [0] motor_select
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [10:0] new_speed, [11] direction, [12] motors_disabled,
    // [28:13] period_slot_0 .. [140:125] period_slot_7, [143:141] zero
    output logic [ssrp_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [ssrp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ssrp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int MOT_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

    logic [ssrp_pkg::ACCEL_W-1:0]  accel_limit_reg;
    logic [ssrp_pkg::PERIOD_W-1:0] dividend_reg;
    ssrp_pkg::cmd_t                cmd;
    ssrp_pkg::status_t             status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_limit_reg <= ssrp_pkg::ACCEL_LIMIT_RESET;
            dividend_reg    <= ssrp_pkg::DIVIDEND_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                ssrp_pkg::CFG_ACCEL_LIMIT: begin
                    accel_limit_reg <= cfg_wdata[ssrp_pkg::ACCEL_W-1:0];
                end
                ssrp_pkg::CFG_PERIOD_DIVIDEND: begin
                    dividend_reg <= cfg_wdata;
                end
                default: ;
            endcase
        end
    end

    ssrp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ssrp_datapath #(
        .NUM_MOTORS (NUM_MOTORS),
        .MOT_W      (MOT_W)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .in_select       (s_axis_tuser),
        .in_target       (signed'(s_axis_tdata[ssrp_pkg::SPEED_W-1:0])),
        .accel_limit     (accel_limit_reg),
        .period_dividend (dividend_reg),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_data        (m_axis_tdata)
    );

    // one transaction in flight: busy straight after an accept
    `SSRP_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // a fresh result is loaded on the same edge the sequencer returns to idle
    `SSRP_ASSERT_SAME(a_result_frees_input, $rose(m_axis_tvalid), s_axis_tready)
    // zero speed gives the idle period in every slot
    `SSRP_ASSERT_SAME(a_zero_speed_period, m_axis_tvalid && (m_axis_tdata[10:0] == 11'd0), (m_axis_tdata[28:13] == 16'hFFFF) && (m_axis_tdata[140:125] == 16'hFFFF))

endmodule

// ===== src/ssrp_ctrl.sv =====
// Sequencer for the ramp / divide / output steps of one transaction.
// Depends on ssrp_pkg.
module ssrp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  ssrp_pkg::status_t status,
    output ssrp_pkg::cmd_t    cmd
);

    ssrp_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ssrp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ssrp_pkg::ST_IDLE: begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid) begin
                    state_next = ssrp_pkg::ST_RAMP;
                end
            end
            ssrp_pkg::ST_RAMP: begin
                cmd.ramp   = 1'b1;
                state_next = ssrp_pkg::ST_DIV;
            end
            ssrp_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ssrp_pkg::ST_DONE;
                end
            end
            ssrp_pkg::ST_DONE: begin
                // wait for the output register to free up
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ssrp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ssrp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/ssrp_datapath.sv =====
// Speed store, ramp limiter, serial restoring divider and result register.
// Depends on ssrp_pkg; driven by ssrp_ctrl through cmd_t / status_t.
module ssrp_datapath #(
    parameter int NUM_MOTORS = 2,
    parameter int MOT_W      = 1
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ssrp_pkg::cmd_t                       cmd,
    output ssrp_pkg::status_t                    status,
    input  logic                                 in_select,
    input  logic signed [ssrp_pkg::SPEED_W-1:0]  in_target,
    input  logic [ssrp_pkg::ACCEL_W-1:0]         accel_limit,
    input  logic [ssrp_pkg::PERIOD_W-1:0]        period_dividend,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ssrp_pkg::M_TDATA_W-1:0]       out_data
);

    localparam logic [3:0] NUM_M    = 4'(NUM_MOTORS);
    localparam logic [3:0] LAST_MOT = 4'(NUM_MOTORS - 1);
    localparam int QW = ssrp_pkg::DIV_STEPS;

    logic [MOT_W-1:0]                    sel_reg;
    logic signed [ssrp_pkg::SPEED_W-1:0] target_reg;
    logic signed [ssrp_pkg::SPEED_W-1:0] speed_reg [NUM_MOTORS];
    logic                                dir_reg   [NUM_MOTORS];
    logic signed [ssrp_pkg::SPEED_W-1:0] new_speed_reg;
    logic [ssrp_pkg::MAG_W-1:0]          mag_reg;
    logic [ssrp_pkg::MAG_W-1:0]          rem_reg;
    logic [QW-1:0]                       quo_reg;
    logic [ssrp_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic                                out_valid_reg;
    logic [ssrp_pkg::M_TDATA_W-1:0]      out_data_reg;

    logic [3:0]                          sel_ext;
    logic [MOT_W-1:0]                    sel_next;
    logic signed [ssrp_pkg::SPEED_W-1:0] target_next;
    logic signed [ssrp_pkg::SPEED_W:0]   cur12, tgt12, acc12, diff12, ramp12;
    logic signed [ssrp_pkg::SPEED_W-1:0] ramp_speed;
    logic [ssrp_pkg::SPEED_W-1:0]        ramp_abs;
    logic [ssrp_pkg::MAG_W:0]            trial;
    logic                                qbit;
    logic [ssrp_pkg::MAG_W-1:0]          rem_next;
    logic                                all_zero;
    logic [ssrp_pkg::PERIOD_W-1:0]       base;
    logic [ssrp_pkg::SUB_W-1:0]          sub;
    logic [ssrp_pkg::M_TDATA_W-1:0]      out_data_next;

    // input capture: select saturates to the last motor, -1024 to -1023
    always_comb begin
        sel_ext = {3'b000, in_select};
        if (sel_ext >= NUM_M) begin
            sel_ext = LAST_MOT;
        end
        sel_next    = sel_ext[MOT_W-1:0];
        target_next = (in_target == ssrp_pkg::SPEED_MIN_PATTERN) ?
                      ssrp_pkg::SPEED_NEG_LIMIT : in_target;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            sel_reg    <= sel_next;
            target_reg <= target_next;
        end
    end

    // acceleration limit
    always_comb begin
        cur12  = {speed_reg[sel_reg][ssrp_pkg::SPEED_W-1], speed_reg[sel_reg]};
        tgt12  = {target_reg[ssrp_pkg::SPEED_W-1], target_reg};
        acc12  = signed'({4'b0000, accel_limit});
        diff12 = cur12 - tgt12;
        if (diff12 > acc12) begin
            ramp12 = cur12 - acc12;
        end else if (diff12 < -acc12) begin
            ramp12 = cur12 + acc12;
        end else begin
            ramp12 = tgt12;
        end
        ramp_speed = ramp12[ssrp_pkg::SPEED_W-1:0];
        ramp_abs   = ramp_speed[ssrp_pkg::SPEED_W-1] ? 11'(-ramp_speed) : 11'(ramp_speed);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_MOTORS; i++) begin
                speed_reg[i] <= '0;
                dir_reg[i]   <= 1'b0;
            end
        end else if (cmd.ramp) begin
            speed_reg[sel_reg] <= ramp_speed;
            if (ramp_speed != '0) begin
                dir_reg[sel_reg] <= ~ramp_speed[ssrp_pkg::SPEED_W-1];
            end
        end
    end

    // restoring divider: (dividend * 8) / |speed|, one quotient bit per cycle
    always_comb begin
        trial = {rem_reg, quo_reg[QW-1]};
        qbit  = (trial >= {1'b0, mag_reg});
        rem_next = qbit ? ssrp_pkg::MAG_W'(trial - {1'b0, mag_reg})
                        : trial[ssrp_pkg::MAG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.ramp) begin
            new_speed_reg <= ramp_speed;
            mag_reg       <= ramp_abs[ssrp_pkg::MAG_W-1:0];
            rem_reg       <= '0;
            quo_reg       <= {period_dividend, {ssrp_pkg::SUB_W{1'b0}}};
            cnt_reg       <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QW-2:0], qbit};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign status.div_last = (cnt_reg == ssrp_pkg::DIV_CNT_W'(ssrp_pkg::DIV_STEPS - 1));
    assign status.out_free = !out_valid_reg || out_ready;

    // result assembly
    always_comb begin
        all_zero = 1'b1;
        for (int i = 0; i < NUM_MOTORS; i++) begin
            if (speed_reg[i] != '0) begin
                all_zero = 1'b0;
            end
        end
        base = quo_reg[QW-1:ssrp_pkg::SUB_W];
        sub  = quo_reg[ssrp_pkg::SUB_W-1:0];
        out_data_next = '0;
        out_data_next[ssrp_pkg::SPEED_W-1:0] = new_speed_reg;
        out_data_next[ssrp_pkg::SPEED_W]     = dir_reg[sel_reg];
        out_data_next[ssrp_pkg::SPEED_W+1]   = all_zero;
        for (int s = 0; s < ssrp_pkg::SLOT_COUNT; s++) begin
            if (new_speed_reg == '0) begin
                out_data_next[ssrp_pkg::SLOT_LSB + s*ssrp_pkg::PERIOD_W +: ssrp_pkg::PERIOD_W] =
                    ssrp_pkg::ZERO_SPEED_PERIOD;
            end else begin
                out_data_next[ssrp_pkg::SLOT_LSB + s*ssrp_pkg::PERIOD_W +: ssrp_pkg::PERIOD_W] =
                    base + ssrp_pkg::PERIOD_W'(sub > ssrp_pkg::slot_rank(3'(s)));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
